// ----- hdl/rgbq_pkg.sv -----
// Shared types, constants and helpers for the RGB to 256-color quantizer.
package rgbq_pkg;

	// Cube level number 0..5
	typedef logic [2:0] level_t;

	// Grey test and ramp bounds
	localparam logic [7:0] NearLimit = 8'd8;
	localparam logic [7:0] GreyLow   = 8'd4;
	localparam logic [7:0] GreyHigh  = 8'd248;
	localparam logic [7:0] GreyBase  = 8'd232;
	localparam logic [7:0] CubeBase  = 8'd16;

	// Mean of three: floor(sum/3) = (sum * 683) >> 11 for sum up to 765
	localparam logic [9:0]  MeanRecip = 10'd683;
	localparam int unsigned MeanShift = 11;

	// Ramp step: floor(x*24/245) = (x * 1643496) >> 24 for x up to 244
	localparam logic [20:0] RampRecip = 21'd1643496;
	localparam int unsigned RampShift = 24;

	// Upper bound of each cube level (ties at the midpoint go to the lower level)
	localparam logic [7:0] Lvl0Max = 8'd47;
	localparam logic [7:0] Lvl1Max = 8'd115;
	localparam logic [7:0] Lvl2Max = 8'd155;
	localparam logic [7:0] Lvl3Max = 8'd195;
	localparam logic [7:0] Lvl4Max = 8'd235;

	// Stage 2 word: grey flag, channel sum and cube levels
	typedef struct packed {
		logic       near;
		logic [9:0] sum;
		level_t     lvl_r;
		level_t     lvl_g;
		level_t     lvl_b;
	} feat_t;

	// Stage 3 word: grey flag, mean and cube index
	typedef struct packed {
		logic       near;
		logic [7:0] mean;
		logic [7:0] cube;
	} mid_t;

	// Snap one channel to the nearest cube level
	function automatic level_t nearest_level(input logic [7:0] v);
		level_t lvl;
		if (v <= Lvl0Max) begin
			lvl = 3'd0;
		end else if (v <= Lvl1Max) begin
			lvl = 3'd1;
		end else if (v <= Lvl2Max) begin
			lvl = 3'd2;
		end else if (v <= Lvl3Max) begin
			lvl = 3'd3;
		end else if (v <= Lvl4Max) begin
			lvl = 3'd4;
		end else begin
			lvl = 3'd5;
		end
		return lvl;
	endfunction

	// Absolute difference of two channels
	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return d;
	endfunction

endpackage

// ----- hdl/rgbq_classify.sv -----
// Stage 2: grey test, channel sum and per-channel cube level.
module rgbq_classify (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic          valid_s1,
	input  logic [7:0]    red_s1,
	input  logic [7:0]    green_s1,
	input  logic [7:0]    blue_s1,
	output logic          valid_s2,
	output rgbq_pkg::feat_t feat_s2
);
	import rgbq_pkg::*;

	feat_t feat_d;

	// Classify the pixel
	always_comb begin
		feat_d.near  = (abs_diff(red_s1, green_s1) < NearLimit) &&
		               (abs_diff(green_s1, blue_s1) < NearLimit);
		feat_d.sum   = {2'b00, red_s1} + {2'b00, green_s1} + {2'b00, blue_s1};
		feat_d.lvl_r = nearest_level(red_s1);
		feat_d.lvl_g = nearest_level(green_s1);
		feat_d.lvl_b = nearest_level(blue_s1);
	end

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// Hold word while stalled
	always_ff @(posedge clk) begin
		if (advance) begin
			feat_s2 <= feat_d;
		end
	end

endmodule

// ----- hdl/rgbq_mean.sv -----
// Stage 3: channel mean by reciprocal multiply and cube palette index.
module rgbq_mean (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic            valid_s2,
	input  rgbq_pkg::feat_t feat_s2,
	output logic            valid_s3,
	output rgbq_pkg::mid_t  mid_s3
);
	import rgbq_pkg::*;

	logic [19:0] mean_prod;
	mid_t        mid_d;

	// Divide sum by three and build the cube index
	always_comb begin
		mean_prod  = feat_s2.sum * MeanRecip;
		mid_d.near = feat_s2.near;
		mid_d.mean = mean_prod[MeanShift +: 8];
		mid_d.cube = CubeBase + (8'd36 * {5'd0, feat_s2.lvl_r})
		           + (8'd6 * {5'd0, feat_s2.lvl_g}) + {5'd0, feat_s2.lvl_b};
	end

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
		end
	end

	// Hold word while stalled
	always_ff @(posedge clk) begin
		if (advance) begin
			mid_s3 <= mid_d;
		end
	end

endmodule

// ----- hdl/rgbq_select.sv -----
// Stage 4: grey ramp step and final choice between ramp and cube.
module rgbq_select (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic           valid_s3,
	input  rgbq_pkg::mid_t mid_s3,
	output logic           valid_s4,
	output logic [7:0]     index_s4
);
	import rgbq_pkg::*;

	logic [7:0]  ramp_x;
	logic [28:0] ramp_prod;
	logic        in_ramp;
	logic [7:0]  index_d;

	// Pick the ramp entry when the pixel is grey and not at either end
	always_comb begin
		ramp_x    = mid_s3.mean - GreyLow;
		ramp_prod = ramp_x * RampRecip;
		in_ramp   = mid_s3.near && (mid_s3.mean >= GreyLow) && (mid_s3.mean <= GreyHigh);
		index_d   = in_ramp ? (GreyBase + {3'd0, ramp_prod[RampShift +: 5]}) : mid_s3.cube;
	end

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s4 <= valid_s3;
		end
	end

	// Hold word while stalled
	always_ff @(posedge clk) begin
		if (advance) begin
			index_s4 <= index_d;
		end
	end

endmodule

// ----- hdl/rgb_to_ansi256_quantizer.sv -----
// An accepted pixel moves from the input register through stages 2 and 3 to its palette index on the output register.
// Throughput: one pixel per cycle; the pipeline holds all four stages while the output
// word waits, and pixel_ready follows index_ready or an empty output register.
// The slowest stage is the ramp step, one 8 by 21 bit constant multiply.
// Reset (arst_n low, asynchronous) clears all stage valid bits; data registers are not reset.
module rgb_to_ansi256_quantizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pixel_valid,
	output logic       pixel_ready,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       index_valid,
	input  logic       index_ready,
	output logic [7:0] palette_index
);
	import rgbq_pkg::*;

	logic       advance;
	logic       valid_s1;
	logic [7:0] red_s1;
	logic [7:0] green_s1;
	logic [7:0] blue_s1;
	logic       valid_s2;
	feat_t      feat_s2;
	logic       valid_s3;
	mid_t       mid_s3;
	logic       valid_s4;
	logic [7:0] index_s4;

	// Move the whole pipeline unless the output word is stuck
	assign advance     = !valid_s4 || index_ready;
	assign pixel_ready = advance;

	// Capture the input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
		end
	end

	rgbq_classify u_classify (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.red_s1   (red_s1),
		.green_s1 (green_s1),
		.blue_s1  (blue_s1),
		.valid_s2 (valid_s2),
		.feat_s2  (feat_s2)
	);

	rgbq_mean u_mean (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.valid_s2 (valid_s2),
		.feat_s2  (feat_s2),
		.valid_s3 (valid_s3),
		.mid_s3   (mid_s3)
	);

	rgbq_select u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.valid_s3 (valid_s3),
		.mid_s3   (mid_s3),
		.valid_s4 (valid_s4),
		.index_s4 (index_s4)
	);

	// Drive the output word
	assign index_valid   = valid_s4;
	assign palette_index = index_s4;

endmodule
